/* rtl/core/mcht_pkg.sv */
// Shared codes and controller/datapath handshake types for the hull core.
`timescale 1ns / 1ps
package mcht_pkg;

	// Operation codes carried by a request.
	localparam logic [1:0] FUNC_CLEAR = 2'd0;
	localparam logic [1:0] FUNC_ADD   = 2'd1;
	localparam logic [1:0] FUNC_QUERY = 2'd2;

	// Result status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// Width of the exact cross products in the redundancy test.
	localparam int PROD_W = 83;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       load;
		logic       clear;
		logic       inc_count;
		logic       dec_count;
		logic       clamp_ptr;
		logic       inc_ptr;
		logic       rd_add;
		logic       rd_query;
		logic       diff_en;
		logic       mlo_en;
		logic       mhi_en;
		logic       sum_en;
		logic       qmul_en;
		logic       qadd_en;
		logic       wr_en;
		logic       out_load;
		logic       out_value_en;
		logic [1:0] out_status;
	} mcht_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic full;
		logic empty;
		logic ge3;
		logic redundant;
		logic has_next;
		logic next_le;
	} mcht_sts_t;

endpackage

/* rtl/core/mcht_dp.sv */
// Datapath of the hull core: line stores, multipliers, counters and result register.
`timescale 1ns / 1ps
module mcht_dp #(
	parameter int HULL_DEPTH = 1024,
	parameter int AW = $clog2(HULL_DEPTH),
	parameter int CW = $clog2(HULL_DEPTH + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  mcht_pkg::mcht_cmd_t       cmd,
	output mcht_pkg::mcht_sts_t       sts,
	input  logic signed [31:0]        line_slope,
	input  logic signed [47:0]        line_intercept,
	input  logic signed [31:0]        query_x,
	output logic signed [63:0]        min_value,
	output logic [CW-1:0]             hull_count,
	output logic [1:0]                status
);
	import mcht_pkg::*;

	localparam logic [CW-1:0] DEPTH_C = CW'(HULL_DEPTH);

	// Line stores.
	logic signed [31:0] slope_mem [HULL_DEPTH];
	logic signed [47:0] icpt_mem  [HULL_DEPTH];

	logic [CW-1:0] count_q;
	logic [AW-1:0] ptr_q;

	logic signed [31:0] m3_q, x_q;
	logic signed [47:0] c3_q;
	logic signed [31:0] rd1_m_q, rd2_m_q;
	logic signed [47:0] rd1_c_q, rd2_c_q;
	logic               has_next_q;

	logic signed [48:0] d31c_q, d21c_q;
	logic signed [32:0] d12m_q, d13m_q;
	logic signed [57:0] pa_lo_q, pb_lo_q, pa_hi_q, pb_hi_q;
	logic signed [PROD_W-1:0] sa_q, sb_q;
	logic signed [63:0] p1_q, p2_q, v1_q, v2_q;

	logic [AW-1:0] addr1, addr2;

	// Read address selection.
	always_comb begin
		if (cmd.rd_add) begin
			addr1 = AW'(count_q - CW'(3));
			addr2 = AW'(count_q - CW'(2));
		end else begin
			addr1 = ptr_q;
			addr2 = ptr_q + AW'(1);
		end
	end

	// Control counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ptr_q   <= '0;
		end else begin
			if (cmd.clear) begin
				count_q <= '0;
				ptr_q   <= '0;
			end else begin
				if (cmd.inc_count) count_q <= count_q + CW'(1);
				if (cmd.dec_count) count_q <= count_q - CW'(1);
				if (cmd.clamp_ptr && (CW'(ptr_q) >= count_q)) ptr_q <= AW'(count_q - CW'(1));
				if (cmd.inc_ptr) ptr_q <= ptr_q + AW'(1);
			end
		end
	end

	// Memory write and registered reads.
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			slope_mem[AW'(count_q - CW'(1))] <= m3_q;
			icpt_mem[AW'(count_q - CW'(1))]  <= c3_q;
		end
		if (cmd.rd_add || cmd.rd_query) begin
			rd1_m_q <= slope_mem[addr1];
			rd1_c_q <= icpt_mem[addr1];
			rd2_m_q <= slope_mem[addr2];
			rd2_c_q <= icpt_mem[addr2];
		end
	end

	// Request capture, arithmetic stages and result register.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			m3_q <= line_slope;
			c3_q <= line_intercept;
			x_q  <= query_x;
		end
		if (cmd.rd_query) has_next_q <= (CW'(ptr_q) + CW'(1)) < count_q;
		if (cmd.diff_en) begin
			d31c_q <= 49'(c3_q) - 49'(rd1_c_q);
			d21c_q <= 49'(rd2_c_q) - 49'(rd1_c_q);
			d12m_q <= 33'(rd1_m_q) - 33'(rd2_m_q);
			d13m_q <= 33'(rd1_m_q) - 33'(m3_q);
		end
		if (cmd.mlo_en) begin
			pa_lo_q <= $signed({1'b0, d31c_q[23:0]}) * d12m_q;
			pb_lo_q <= $signed({1'b0, d21c_q[23:0]}) * d13m_q;
		end
		if (cmd.mhi_en) begin
			pa_hi_q <= $signed(d31c_q[48:24]) * d12m_q;
			pb_hi_q <= $signed(d21c_q[48:24]) * d13m_q;
		end
		if (cmd.sum_en) begin
			sa_q <= (PROD_W'(pa_hi_q) <<< 24) + PROD_W'(pa_lo_q);
			sb_q <= (PROD_W'(pb_hi_q) <<< 24) + PROD_W'(pb_lo_q);
		end
		if (cmd.qmul_en) begin
			p1_q <= 64'(rd1_m_q) * 64'(x_q);
			p2_q <= 64'(rd2_m_q) * 64'(x_q);
		end
		if (cmd.qadd_en) begin
			v1_q <= p1_q + 64'(rd1_c_q);
			v2_q <= p2_q + 64'(rd2_c_q);
		end
		if (cmd.out_load) begin
			min_value  <= cmd.out_value_en ? v1_q : 64'sd0;
			hull_count <= count_q;
			status     <= cmd.out_status;
		end
	end

	// Status toward the controller.
	always_comb begin
		sts.full      = (count_q == DEPTH_C);
		sts.empty     = (count_q == '0);
		sts.ge3       = (count_q >= CW'(3));
		sts.redundant = (sa_q <= sb_q);
		sts.has_next  = has_next_q;
		sts.next_le   = (v2_q <= v1_q);
	end

endmodule

/* rtl/core/mcht_ctrl.sv */
// Controller state machine of the hull core.
`timescale 1ns / 1ps
module mcht_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          func,
	output logic                out_valid,
	input  logic                out_stall,
	output mcht_pkg::mcht_cmd_t cmd,
	input  mcht_pkg::mcht_sts_t sts
);
	import mcht_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_DISPATCH, S_ADD_CHECK, S_ADD_DIFF, S_ADD_MLO, S_ADD_MHI,
		S_ADD_SUM, S_ADD_CMP, S_ADD_WRITE, S_Q_READ, S_Q_MUL, S_Q_ADD,
		S_Q_CMP, S_FINISH
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] func_q;
	logic [1:0] st_q, st_d;
	logic       val_q, val_d;
	logic       out_free;
	logic       accept;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid || !out_stall;

	// Next state and datapath commands.
	always_comb begin
		state_d = state_q;
		st_d    = st_q;
		val_d   = val_q;
		cmd     = '0;
		cmd.out_value_en = val_q;
		cmd.out_status   = st_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.load = 1'b1;
					state_d  = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				st_d  = ST_OK;
				val_d = 1'b0;
				state_d = S_FINISH;
				case (func_q)
					FUNC_CLEAR: cmd.clear = 1'b1;
					FUNC_ADD: begin
						if (sts.full) begin
							st_d = ST_FULL;
						end else begin
							cmd.inc_count = 1'b1;
							state_d = S_ADD_CHECK;
						end
					end
					FUNC_QUERY: begin
						if (sts.empty) begin
							st_d = ST_EMPTY;
						end else begin
							cmd.clamp_ptr = 1'b1;
							state_d = S_Q_READ;
						end
					end
					default: ;
				endcase
			end
			S_ADD_CHECK: begin
				if (sts.ge3) begin
					cmd.rd_add = 1'b1;
					state_d = S_ADD_DIFF;
				end else begin
					state_d = S_ADD_WRITE;
				end
			end
			S_ADD_DIFF: begin
				cmd.diff_en = 1'b1;
				state_d = S_ADD_MLO;
			end
			S_ADD_MLO: begin
				cmd.mlo_en = 1'b1;
				state_d = S_ADD_MHI;
			end
			S_ADD_MHI: begin
				cmd.mhi_en = 1'b1;
				state_d = S_ADD_SUM;
			end
			S_ADD_SUM: begin
				cmd.sum_en = 1'b1;
				state_d = S_ADD_CMP;
			end
			S_ADD_CMP: begin
				if (sts.redundant) begin
					cmd.dec_count = 1'b1;
					state_d = S_ADD_CHECK;
				end else begin
					state_d = S_ADD_WRITE;
				end
			end
			S_ADD_WRITE: begin
				cmd.wr_en = 1'b1;
				state_d = S_FINISH;
			end
			S_Q_READ: begin
				cmd.rd_query = 1'b1;
				state_d = S_Q_MUL;
			end
			S_Q_MUL: begin
				cmd.qmul_en = 1'b1;
				state_d = S_Q_ADD;
			end
			S_Q_ADD: begin
				cmd.qadd_en = 1'b1;
				state_d = S_Q_CMP;
			end
			S_Q_CMP: begin
				if (sts.has_next && sts.next_le) begin
					cmd.inc_ptr = 1'b1;
					state_d = S_Q_READ;
				end else begin
					val_d = 1'b1;
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State and registered outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			func_q    <= FUNC_CLEAR;
			st_q      <= ST_OK;
			val_q     <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
			val_q   <= val_d;
			if (accept) func_q <= func;
			if (cmd.out_load) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule

/* rtl/core/monotone_convex_hull_trick_core.sv */
// Top level of the monotone convex hull trick core (minimum envelope).
//
//   channel | direction | handshake             | payload
//   in      | request   | in_valid / in_stall   | func, line_slope, line_intercept, query_x
//   out     | result    | out_valid / out_stall | min_value, hull_count, status
//
// A clear, a rejected request or an unused code goes from dispatch straight to finish.
// An add tests the last three lines in steps (differences, low and high partial products
// of the cross products, sum, compare), drops the middle line while it is redundant, then
// writes the new line. A query clamps the pointer, then per pointer step reads two lines,
// forms slope times x with a 32x32 multiply, adds the intercepts and compares the values.
// The next request is taken in the idle state; a stalled result holds the core.
// Reset is asynchronous and empties the hull; the line stores need no clearing.
`timescale 1ns / 1ps
module monotone_convex_hull_trick_core #(
	parameter int HULL_DEPTH = 1024
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [1:0]                            func,
	input  logic signed [31:0]                    line_slope,
	input  logic signed [47:0]                    line_intercept,
	input  logic signed [31:0]                    query_x,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [63:0]                    min_value,
	output logic [$clog2(HULL_DEPTH + 1)-1:0]     hull_count,
	output logic [1:0]                            status
);
	import mcht_pkg::*;

	mcht_cmd_t cmd;
	mcht_sts_t sts;

	// Sequencer.
	mcht_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Stores and arithmetic.
	mcht_dp #(
		.HULL_DEPTH (HULL_DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.line_slope     (line_slope),
		.line_intercept (line_intercept),
		.query_x        (query_x),
		.min_value      (min_value),
		.hull_count     (hull_count),
		.status         (status)
	);

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the monotone convex hull trick core.
`timescale 1ns / 1ps
module tb_top;
	import mcht_pkg::*;

	localparam int DEPTH = 1024;

	// Selector value that the core ignores.
	localparam logic [1:0] FUNC_NONE = 2'd3;

	typedef struct {
		longint     min_value;
		logic [10:0] hull_count;
		logic [1:0] status;
	} hull_result_t;

	typedef struct {
		logic [1:0] fn;
		longint     m;
		longint     c;
		longint     x;
		bit         fixed;
		longint     v;
		int         cnt;
		logic [1:0] st;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] func = FUNC_CLEAR;
	logic signed [31:0] line_slope = '0;
	logic signed [47:0] line_intercept = '0;
	logic signed [31:0] query_x = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [63:0] min_value;
	logic [10:0] hull_count;
	logic [1:0] status;

	// Shadow copy of the hull.
	int     env_slope [DEPTH];
	longint env_icpt [DEPTH];
	int     env_count;
	int     env_ptr;

	hull_result_t pending_q[$];
	int errors = 0;
	int n_sent = 0;
	int n_checked = 0;
	int n_full = 0;
	int n_empty = 0;
	int burst_left = 0;
	bit hold_req = 1'b0;

	monotone_convex_hull_trick_core #(.HULL_DEPTH(DEPTH)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .line_slope(line_slope), .line_intercept(line_intercept),
		.query_x(query_x),
		.out_valid(out_valid), .out_stall(out_stall),
		.min_value(min_value), .hull_count(hull_count), .status(status)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("Timeout at %0t with %0d results outstanding", $time, pending_q.size());
		$display("TEST FAILED");
		$finish;
	end

	function automatic longint line_at(int idx, longint x);
		return longint'(env_slope[idx]) * x + env_icpt[idx];
	endfunction

	// Exact cross-multiplied test on three consecutive lines.
	function automatic bit middle_dead(int i);
		logic signed [127:0] dc3, dm2, dc2, dm3;
		dc3 = env_icpt[i + 2] - env_icpt[i];
		dm2 = longint'(env_slope[i]) - longint'(env_slope[i + 1]);
		dc2 = env_icpt[i + 1] - env_icpt[i];
		dm3 = longint'(env_slope[i]) - longint'(env_slope[i + 2]);
		return (dc3 * dm2) <= (dc2 * dm3);
	endfunction

	// Apply one request to the shadow hull and return its result.
	function automatic hull_result_t hull_apply(logic [1:0] fn, longint m, longint c,
			longint x);
		hull_result_t r;
		r.min_value = 0;
		r.status = ST_OK;
		if (fn == FUNC_CLEAR) begin
			env_count = 0;
			env_ptr = 0;
		end else if (fn == FUNC_ADD) begin
			if (env_count >= DEPTH) begin
				r.status = ST_FULL;
			end else begin
				env_slope[env_count] = int'(m);
				env_icpt[env_count] = c;
				env_count++;
				while (env_count >= 3 && middle_dead(env_count - 3)) begin
					env_slope[env_count - 2] = env_slope[env_count - 1];
					env_icpt[env_count - 2] = env_icpt[env_count - 1];
					env_count--;
				end
			end
		end else if (fn == FUNC_QUERY) begin
			if (env_count == 0) begin
				r.status = ST_EMPTY;
			end else begin
				if (env_ptr >= env_count)
					env_ptr = env_count - 1;
				while (env_ptr + 1 < env_count && line_at(env_ptr + 1, x) <= line_at(env_ptr, x))
					env_ptr++;
				r.min_value = line_at(env_ptr, x);
			end
		end
		r.hull_count = env_count[10:0];
		return r;
	endfunction

	// Offer one request in bursts with random gaps; predict on acceptance.
	task automatic send_req(logic [1:0] fn, longint m, longint c, longint x,
			bit fixed = 0, longint v = 0, int cnt = 0, logic [1:0] st = ST_OK);
		hull_result_t r;
		int g;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			g = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
			if (g > 0) begin
				in_valid <= 1'b0;
				repeat (g) @(negedge clk);
			end
		end
		burst_left--;
		func <= fn;
		line_slope <= m[31:0];
		line_intercept <= c[47:0];
		query_x <= x[31:0];
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		r = hull_apply(fn, longint'($signed(m[31:0])), longint'($signed(c[47:0])),
			longint'($signed(x[31:0])));
		if (fixed) begin
			r.min_value = v;
			r.hull_count = cnt[10:0];
			r.status = st;
		end
		if (r.status == ST_FULL) n_full++;
		if (r.status == ST_EMPTY) n_empty++;
		pending_q.insert(pending_q.size(), r);
		n_sent++;
	endtask

	// Receiver stall pattern, with one long hold-off on request.
	initial begin
		int phase;
		int mode;
		bit held;
		phase = 0;
		mode = 0;
		held = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !held) begin
				held = 1'b1;
				out_stall <= 1'b1;
				repeat (400) @(negedge clk);
			end
			if (phase % 50 == 0)
				mode = $urandom_range(0, 2);
			phase++;
			case (mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 2) == 0);
				default: out_stall <= ((phase % 7) < 3);
			endcase
		end
	end

	// Compare each delivered result with the oldest prediction.
	always @(posedge clk) begin
		hull_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected result value=%0d count=%0d status=%0d",
					$time, min_value, hull_count, status);
				errors++;
			end else begin
				e = pending_q.pop_front();
				n_checked++;
				if (min_value !== e.min_value) begin
					$display("%0t: min_value expected %0d actual %0d", $time, e.min_value,
						min_value);
					errors++;
				end
				if (hull_count !== e.hull_count) begin
					$display("%0t: hull_count expected %0d actual %0d", $time, e.hull_count,
						hull_count);
					errors++;
				end
				if (status !== e.status) begin
					$display("%0t: status expected %0d actual %0d", $time, e.status, status);
					errors++;
				end
			end
		end
	end

	// Random signed value of up to bits wide, shrunk by a random scale.
	function automatic longint rnd_val(int bits, int scale);
		longint v;
		v = longint'({$urandom, $urandom});
		v = v <<< (64 - bits);
		v = v >>> (64 - bits + scale);
		return v;
	endfunction

	initial begin
		dir_row_t dir_tab[$];
		longint m_max, m_min, c_max, c_min, x_max, x_min;
		longint slope_cur, x_cur, step;
		int scale, n_add, k, total;
		m_max = 64'sd2147483647;
		m_min = -64'sd2147483648;
		c_max = 64'sd140737488355327;
		c_min = -64'sd140737488355328;
		x_max = m_max;
		x_min = m_min;
		env_count = 0;
		env_ptr = 0;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed rows: fixed where the answer is obvious, else predicted.
		dir_tab.insert(dir_tab.size(), '{FUNC_QUERY, 0, 0, 5, 1, 0, 0, ST_EMPTY});
		dir_tab.insert(dir_tab.size(), '{FUNC_NONE, m_min, c_min, x_min, 1, 0, 0, ST_OK});
		dir_tab.insert(dir_tab.size(), '{FUNC_ADD, m_max, c_max, 0, 1, 0, 1, ST_OK});
		dir_tab.insert(dir_tab.size(), '{FUNC_QUERY, 0, 0, x_min, 0, 0, 0, ST_OK});
		dir_tab.insert(dir_tab.size(), '{FUNC_QUERY, 0, 0, 0, 1, c_max, 1, ST_OK});
		dir_tab.insert(dir_tab.size(), '{FUNC_ADD, m_min, c_min, 0, 1, 0, 2, ST_OK});
		dir_tab.insert(dir_tab.size(), '{FUNC_QUERY, 0, 0, x_max, 0, 0, 0, ST_OK});
		dir_tab.insert(dir_tab.size(), '{FUNC_NONE, 7, 7, 7, 1, 0, 2, ST_OK});
		dir_tab.insert(dir_tab.size(), '{FUNC_CLEAR, m_max, c_max, x_max, 1, 0, 0, ST_OK});
		dir_tab.insert(dir_tab.size(), '{FUNC_QUERY, 0, 0, x_max, 1, 0, 0, ST_EMPTY});
		// Equal slopes, a redundant middle line, then a collinear triple.
		dir_tab.insert(dir_tab.size(), '{FUNC_ADD, 5, 100, 0, 0, 0, 0, ST_OK});
		dir_tab.insert(dir_tab.size(), '{FUNC_ADD, 5, 50, 0, 0, 0, 0, ST_OK});
		dir_tab.insert(dir_tab.size(), '{FUNC_ADD, 0, 1000, 0, 0, 0, 0, ST_OK});
		dir_tab.insert(dir_tab.size(), '{FUNC_ADD, -5, 50, 0, 0, 0, 0, ST_OK});
		dir_tab.insert(dir_tab.size(), '{FUNC_ADD, -10, 50, 0, 0, 0, 0, ST_OK});
		dir_tab.insert(dir_tab.size(), '{FUNC_ADD, -15, 50, 0, 0, 0, 0, ST_OK});
		dir_tab.insert(dir_tab.size(), '{FUNC_QUERY, 0, 0, -100, 0, 0, 0, ST_OK});
		dir_tab.insert(dir_tab.size(), '{FUNC_QUERY, 0, 0, 0, 0, 0, 0, ST_OK});
		dir_tab.insert(dir_tab.size(), '{FUNC_QUERY, 0, 0, 100, 0, 0, 0, ST_OK});
		// Out-of-order x and slope run the same steps anyway.
		dir_tab.insert(dir_tab.size(), '{FUNC_QUERY, 0, 0, -100, 0, 0, 0, ST_OK});
		dir_tab.insert(dir_tab.size(), '{FUNC_ADD, 20, -7, 0, 0, 0, 0, ST_OK});
		dir_tab.insert(dir_tab.size(), '{FUNC_QUERY, 0, 0, x_min, 0, 0, 0, ST_OK});
		dir_tab.insert(dir_tab.size(), '{FUNC_QUERY, 0, 0, x_max, 0, 0, 0, ST_OK});
		dir_tab.insert(dir_tab.size(), '{FUNC_CLEAR, 0, 0, 0, 1, 0, 0, ST_OK});
		foreach (dir_tab[i])
			send_req(dir_tab[i].fn, dir_tab[i].m, dir_tab[i].c, dir_tab[i].x,
				dir_tab[i].fixed, dir_tab[i].v, dir_tab[i].cnt, dir_tab[i].st);

		// Fill the store with tangents of a parabola so every line stays kept.
		for (int i = 0; i < DEPTH; i++)
			send_req(FUNC_ADD, -i, longint'(i) * i, 0);
		send_req(FUNC_ADD, -DEPTH, longint'(DEPTH) * DEPTH, 0, 1, 0, DEPTH, ST_FULL);
		for (int i = 0; i < 16; i++)
			send_req(FUNC_QUERY, 0, 0, -100 + i * 150);
		send_req(FUNC_ADD, m_min, c_min, 0, 1, 0, DEPTH, ST_FULL);
		send_req(FUNC_CLEAR, 0, 0, 0, 1, 0, 0, ST_OK);

		// Random episodes: ordered adds and queries, with some noise.
		hold_req = 1'b1;
		total = 0;
		while (total < 60) begin
			if ($urandom_range(0, 9) == 0) begin
				send_req(2'($urandom_range(0, 3)), rnd_val(32, 0), rnd_val(48, 0),
					rnd_val(32, 0));
				total++;
				continue;
			end
			if ($urandom_range(0, 4) != 0) begin
				send_req(FUNC_CLEAR, 0, 0, 0);
				total++;
			end
			scale = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(8, 28);
			n_add = $urandom_range(0, 7) == 0 ? $urandom_range(40, 120) : $urandom_range(1, 30);
			slope_cur = rnd_val(32, scale);
			x_cur = rnd_val(32, scale);
			k = 0;
			while (k < n_add) begin
				if ($urandom_range(0, 2) != 0) begin
					send_req(FUNC_ADD, slope_cur, rnd_val(48, scale), 0);
					k++;
					step = $urandom_range(0, 3) == 0 ? 0 :
						longint'($urandom_range(0, 65535)) << ($urandom_range(0, 31 - scale / 2));
					slope_cur = (slope_cur - step < m_min) ? m_min : slope_cur - step;
				end else begin
					send_req(FUNC_QUERY, 0, 0, x_cur);
					step = $urandom_range(0, 3) == 0 ? 0 :
						longint'($urandom_range(0, 65535)) << ($urandom_range(0, 31 - scale / 2));
					x_cur = (x_cur + step > x_max) ? x_max : x_cur + step;
				end
				total++;
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);

		$display("Covered %0d requests, %0d results checked, %0d full-store and %0d",
			n_sent, n_checked, n_full, n_empty);
		$display("empty-hull rejections, a filled store and one long output hold-off.");
		if (errors == 0 && pending_q.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("Errors: %0d", errors);
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

/* files.f */
rtl/core/mcht_pkg.sv
rtl/core/mcht_dp.sv
rtl/core/mcht_ctrl.sv
rtl/core/monotone_convex_hull_trick_core.sv
tb/tb_top.sv
